// File: sv/acf_pkg.sv
`timescale 1ns / 1ps

package acf_pkg;

    // sizes of the design
    localparam int PRE_MAX    = 16;
    localparam int HEADER_MAX = 1023;

    localparam int PRE_IDX_W  = (PRE_MAX > 1) ? $clog2(PRE_MAX) : 1;
    localparam int PRE_FILL_W = $clog2(PRE_MAX + 1);

    localparam int HDR_LEN_W  = 10;
    localparam int PRE_LEN_W  = 5;
    localparam int POST_LEN_W = 8;
    localparam int FILT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int COUNT_W    = 16;
    localparam int BYTE_W     = 8;

    localparam logic [COUNT_W-1:0] LEN_MIN = COUNT_W'(3);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_LENGTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST_LENGTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_CATEGORY = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PRE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_POST,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_CAT
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       record_last;
        logic       record_cut;
        logic       header_short;
        logic       length_bad;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic step;
        logic emit_pre;
        logic emit_cat;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic flush_req;
        logic idx_last;
    } dp_status_t;

endpackage

// File: sv/acf_ctrl.sv
`timescale 1ns / 1ps

module acf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  acf_pkg::dp_status_t status,
    output acf_pkg::ctrl_cmd_t  cmd
);
    import acf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (s_valid && status.out_free && status.flush_req) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (status.out_free && status.idx_last) begin
                    state_next = ST_CAT;
                end
            end
            ST_CAT: begin
                if (status.out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd.step     = 1'b0;
        cmd.emit_pre = 1'b0;
        cmd.emit_cat = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_ready  = status.out_free;
                cmd.step = s_valid && status.out_free;
            end
            ST_FLUSH: begin
                cmd.emit_pre = status.out_free;
            end
            ST_CAT: begin
                cmd.emit_cat = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.step, cmd.emit_pre, cmd.emit_cat}))
        else $error("more than one datapath command at once");

    a_flush_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.flush_req) |=> (state_reg == ST_FLUSH))
        else $error("held pre bytes not flushed");

    a_flush_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_pre && status.idx_last) |=> (state_reg == ST_CAT))
        else $error("category byte not sent after pre bytes");

    a_cat_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_cat |=> (state_reg == ST_RUN))
        else $error("controller stuck after category byte");

endmodule

// File: sv/acf_datapath.sv
`timescale 1ns / 1ps

module acf_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [acf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [acf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  acf_pkg::in_item_t                     s_data,
    input  acf_pkg::ctrl_cmd_t                    cmd,
    output acf_pkg::dp_status_t                   status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output acf_pkg::out_item_t                    m_data
);
    import acf_pkg::*;

    // configuration
    logic [HDR_LEN_W-1:0]  header_length_reg;
    logic [PRE_LEN_W-1:0]  pre_length_reg;
    logic [POST_LEN_W-1:0] post_length_reg;
    logic signed [FILT_W-1:0] filter_category_reg;

    // record state
    phase_t                phase_reg,        phase_next;
    logic [COUNT_W-1:0]    byte_count_reg,   byte_count_next;
    logic [COUNT_W-1:0]    block_length_reg, block_length_next;
    logic                  keep_reg,         keep_next;
    logic [PRE_FILL_W-1:0] pre_fill_reg,     pre_fill_next;
    logic [PRE_IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0]     cat_byte_reg;
    logic [BYTE_W-1:0]     pre_store [PRE_MAX];

    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    // decode of the offered item
    logic [HDR_LEN_W-1:0]  hlen;
    logic [PRE_LEN_W-1:0]  plen;
    phase_t                eff_phase;
    logic [BYTE_W-1:0]     b;
    logic                  cat_kept;
    logic [FILT_W-1:0]     filt_mag;
    logic                  pre_wr;
    logic                  emit_now;
    out_item_t             emit_item;
    logic                  flush_req;
    logic [COUNT_W-1:0]    bc_inc;
    logic [COUNT_W-1:0]    bl_full;
    logic                  done;

    always_comb begin
        hlen = (header_length_reg > HDR_LEN_W'(HEADER_MAX)) ?
               HDR_LEN_W'(HEADER_MAX) : header_length_reg;
        plen = (pre_length_reg > PRE_LEN_W'(PRE_MAX)) ?
               PRE_LEN_W'(PRE_MAX) : pre_length_reg;
    end

    always_comb begin
        filt_mag = FILT_W'(-filter_category_reg);
        b        = s_data.in_byte;
        if (filter_category_reg > 0) begin
            cat_kept = (filter_category_reg[BYTE_W-1:0] == b);
        end else if (filter_category_reg < 0) begin
            cat_kept = (filt_mag != FILT_W'(b));
        end else begin
            cat_kept = 1'b0;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        block_length_next = block_length_reg;
        keep_next         = keep_reg;
        pre_fill_next     = pre_fill_reg;
        pre_wr            = 1'b0;
        emit_now          = 1'b0;
        flush_req         = 1'b0;
        emit_item         = '0;
        emit_item.run_last = 1'b1;
        bc_inc            = byte_count_reg + COUNT_W'(1);
        bl_full           = {block_length_reg[COUNT_W-1:BYTE_W], b};
        done              = 1'b0;

        if (phase_reg == PH_HEADER && byte_count_reg >= COUNT_W'(hlen)) begin
            eff_phase = PH_PRE;
        end else begin
            eff_phase = phase_reg;
        end

        if (s_data.stream_end) begin
            emit_now               = 1'b1;
            emit_item.record_cut   = keep_reg;
            emit_item.header_short = (phase_reg == PH_HEADER) &&
                                     (byte_count_reg < COUNT_W'(hlen));
            phase_next        = PH_HEADER;
            byte_count_next   = '0;
            block_length_next = '0;
            keep_next         = 1'b0;
            pre_fill_next     = '0;
        end else begin
            phase_next = eff_phase;
            case (eff_phase)
                PH_HEADER: begin
                    emit_now             = 1'b1;
                    emit_item.out_byte   = b;
                    emit_item.byte_valid = 1'b1;
                    byte_count_next      = bc_inc;
                end
                PH_PRE: begin
                    if (pre_fill_reg < plen) begin
                        pre_wr        = 1'b1;
                        pre_fill_next = pre_fill_reg + PRE_FILL_W'(1);
                    end else begin
                        keep_next  = cat_kept;
                        phase_next = PH_LEN_HI;
                        if (cat_kept) begin
                            if (pre_fill_reg != '0) begin
                                flush_req = 1'b1;
                            end else begin
                                emit_now             = 1'b1;
                                emit_item.out_byte   = b;
                                emit_item.byte_valid = 1'b1;
                            end
                        end
                    end
                end
                PH_LEN_HI: begin
                    block_length_next    = {b, {BYTE_W{1'b0}}};
                    emit_now             = keep_reg;
                    emit_item.out_byte   = b;
                    emit_item.byte_valid = 1'b1;
                    phase_next           = PH_LEN_LO;
                end
                PH_LEN_LO, PH_PAYLOAD: begin
                    if (eff_phase == PH_LEN_LO) begin
                        block_length_next = bl_full;
                    end
                    if (eff_phase == PH_LEN_LO && bl_full < LEN_MIN) begin
                        // bad length: flag it and halt until stream end
                        emit_now             = 1'b1;
                        emit_item.record_cut = keep_reg;
                        emit_item.length_bad = 1'b1;
                        keep_next            = 1'b0;
                        pre_fill_next        = '0;
                        phase_next           = PH_HALT;
                    end else begin
                        if (eff_phase == PH_LEN_LO) begin
                            done = (LEN_MIN >= bl_full);
                        end else begin
                            done = (bc_inc >= block_length_reg);
                        end
                        emit_now              = keep_reg;
                        emit_item.out_byte    = b;
                        emit_item.byte_valid  = 1'b1;
                        emit_item.record_last = done && (post_length_reg == '0);
                        if (!done) begin
                            phase_next      = PH_PAYLOAD;
                            byte_count_next = (eff_phase == PH_LEN_LO) ? LEN_MIN : bc_inc;
                        end else if (post_length_reg == '0) begin
                            phase_next      = PH_PRE;
                            pre_fill_next   = '0;
                            keep_next       = 1'b0;
                            byte_count_next = '0;
                        end else begin
                            phase_next      = PH_POST;
                            byte_count_next = '0;
                        end
                    end
                end
                PH_POST: begin
                    done                  = (bc_inc >= COUNT_W'(post_length_reg));
                    emit_now              = keep_reg;
                    emit_item.out_byte    = b;
                    emit_item.byte_valid  = 1'b1;
                    emit_item.record_last = done;
                    if (done) begin
                        phase_next      = PH_PRE;
                        pre_fill_next   = '0;
                        keep_next       = 1'b0;
                        byte_count_next = '0;
                    end else begin
                        byte_count_next = bc_inc;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        status.out_free  = !out_valid_reg || m_ready;
        status.flush_req = flush_req;
        status.idx_last  = (pre_fill_reg == (PRE_FILL_W'(idx_reg) + PRE_FILL_W'(1)));
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_length_reg   <= '0;
            pre_length_reg      <= '0;
            post_length_reg     <= '0;
            filter_category_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HEADER_LENGTH:   header_length_reg   <= cfg_wdata[HDR_LEN_W-1:0];
                REG_PRE_LENGTH:      pre_length_reg      <= cfg_wdata[PRE_LEN_W-1:0];
                REG_POST_LENGTH:     post_length_reg     <= cfg_wdata[POST_LEN_W-1:0];
                REG_FILTER_CATEGORY: filter_category_reg <= cfg_wdata[FILT_W-1:0];
                default: begin
                    header_length_reg <= header_length_reg;
                end
            endcase
        end
    end

    // record state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            byte_count_reg   <= '0;
            block_length_reg <= '0;
            keep_reg         <= 1'b0;
            pre_fill_reg     <= '0;
            idx_reg          <= '0;
        end else if (cmd.step) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            block_length_reg <= block_length_next;
            keep_reg         <= keep_next;
            pre_fill_reg     <= pre_fill_next;
            idx_reg          <= '0;
        end else if (cmd.emit_pre) begin
            idx_reg <= idx_reg + PRE_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && pre_wr) begin
            pre_store[pre_fill_reg[PRE_IDX_W-1:0]] <= b;
        end
        if (cmd.step && flush_req) begin
            cat_byte_reg <= b;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.step && emit_now) || cmd.emit_pre || cmd.emit_cat) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && emit_now) begin
            out_data_reg <= emit_item;
        end else if (cmd.emit_pre) begin
            out_data_reg <= '{out_byte: pre_store[idx_reg], byte_valid: 1'b1,
                              default: 1'b0};
        end else if (cmd.emit_cat) begin
            out_data_reg <= '{out_byte: cat_byte_reg, byte_valid: 1'b1,
                              run_last: 1'b1, default: 1'b0};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: sv/asterix_category_filter.sv
`timescale 1ns / 1ps
// output: a result sits in the output register in the cycle after its request is taken
// rate: one request per cycle outside a flush while results drain, one result per cycle
// a kept category byte with n held pre bytes holds the input while they are sent:
// its own request loads nothing, then n + 1 results load in order (flush sequencer)
// reset: synchronous active-low aresetn clears state, configuration and m_valid

module asterix_category_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [acf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // byte requests in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  acf_pkg::in_item_t              s_data,
    // results out
    output logic                           m_valid,
    input  logic                           m_ready,
    output acf_pkg::out_item_t             m_data
);
    import acf_pkg::*;

    // commands from the sequencer, status back from the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: takes requests, then walks the held pre bytes out
    // ahead of a kept category byte
    acf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: record parser, pre byte store, filter compare,
    // configuration registers and the output register
    acf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
